FILE: rtl/csrr_pkg.sv
// ----------------------------------------------------------------------------
// csrr_pkg
// Shared constants, types and a byte-mask helper of the slot relay responder.
// ----------------------------------------------------------------------------
package csrr_pkg;

   localparam int QUEUE_DEPTH_DEF = 8;

   localparam int ID_W      = 11;
   localparam int LEN_W     = 4;
   localparam int DATA_W    = 64;
   localparam int OFS_W     = 5;
   localparam int RID_W     = 16;
   localparam int HDR_W     = LEN_W + ID_W;
   localparam int ENTRY_W   = HDR_W + DATA_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 11;

   localparam logic [OFS_W-1:0] WINDOW_SPAN = 5'h1F;
   localparam logic [OFS_W-1:0] OFS_STATUS  = 5'h10;
   localparam logic [LEN_W-1:0] HDR_BYTES   = 4'd3;
   localparam logic [LEN_W-1:0] FRAG_BYTES  = 4'd5;
   localparam logic [LEN_W-1:0] MAX_BYTES   = 4'd8;
   localparam logic [LEN_W-1:0] STATUS_LEN  = 4'd2;
   localparam logic [7:0]       BYTE_MASK   = 8'hFF;

   localparam logic [CSR_IDX_W-1:0] CSR_WIN_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEND_OFS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECV_OFS = 2'd2;

   localparam logic [ID_W-1:0]  WIN_BASE_RST = 11'd0;
   localparam logic [OFS_W-1:0] SEND_OFS_RST = 5'd17;
   localparam logic [OFS_W-1:0] RECV_OFS_RST = 5'd18;

   localparam logic PORT_UPLINK   = 1'b0;
   localparam logic PORT_DOWNLINK = 1'b1;

   typedef struct packed {
      logic push;
      logic pop;
   } q_ctrl_type;

   typedef struct packed {
      logic              valid;
      logic              recv;
      logic              port;
      logic [RID_W-1:0]  id;
      logic [LEN_W-1:0]  len;
      logic [DATA_W-1:0] payload;
   } s1_word_type;

   function automatic logic [DATA_W-1:0] bytes_mask(input logic [LEN_W-1:0] n);
      logic [DATA_W-1:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         m[i*8 +: 8] = (LEN_W'(i) < n) ? BYTE_MASK : 8'h00;
      end
      return m;
   endfunction

endpackage

FILE: rtl/csrr_queue.sv
// ----------------------------------------------------------------------------
// csrr_queue
// Captured frame queue: one memory, write and read pointers, fill count.
// A push onto a full queue drops the oldest entry.
// ----------------------------------------------------------------------------
module csrr_queue
   import csrr_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  q_ctrl_type         ctrl,
   input  logic [ENTRY_W-1:0] wr_data,
   output logic               empty,
   output logic [ENTRY_W-1:0] rd_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
   logic [ENTRY_W-1:0] rd_ff;
   logic [PTR_W-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               full;

   assign full    = (cnt_ff == CNT_FULL);
   assign empty   = (cnt_ff == '0);
   assign rd_data = rd_ff;

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (ctrl.push) begin
         wp_in = (wp_ff == PTR_LAST) ? '0 : wp_ff + 1'b1;
         if (full) begin
            rp_in = (rp_ff == PTR_LAST) ? '0 : rp_ff + 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end else if (ctrl.pop) begin
         rp_in  = (rp_ff == PTR_LAST) ? '0 : rp_ff + 1'b1;
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[wp_ff] <= wr_data;
      end
      if (ctrl.pop) begin
         rd_ff <= mem[rp_ff];
      end
   end

endmodule

FILE: rtl/csrr_out.sv
// ----------------------------------------------------------------------------
// csrr_out
// Result register with a second-fragment holding stage. Splits a popped
// queue entry into one or two uplink fragments.
// ----------------------------------------------------------------------------
module csrr_out
   import csrr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  s1_word_type        s1,
   input  logic [ENTRY_W-1:0] rd_data,
   output logic               s1_take,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_reply_port,
   output logic [RID_W-1:0]   rsp_reply_id,
   output logic [LEN_W-1:0]   rsp_reply_length,
   output logic [DATA_W-1:0]  rsp_reply_payload,
   output logic               rsp_last_of_run
);

   logic               valid_ff, pend_ff;
   logic               port_ff, last_ff;
   logic [RID_W-1:0]   id_ff;
   logic [LEN_W-1:0]   len_ff, pend_len_ff;
   logic [DATA_W-1:0]  pay_ff, pend_pay_ff;

   logic [LEN_W-1:0]   flen, first_n, len1, len2;
   logic [ID_W-1:0]    fid;
   logic [DATA_W-1:0]  data, mask1, pay1, pay2;
   logic [23:0]        head;
   logic               split, out_free, rsp_fire;

   assign flen    = rd_data[ENTRY_W-1 -: LEN_W];
   assign fid     = rd_data[DATA_W +: ID_W];
   assign data    = rd_data[DATA_W-1:0];
   assign split   = (flen > FRAG_BYTES);
   assign first_n = split ? FRAG_BYTES : flen;
   assign mask1   = bytes_mask(first_n);
   assign head    = {4'b0, flen, fid[7:0], 5'b0, fid[ID_W-1:8]};
   assign pay1    = {data[39:0] & mask1[39:0], head};
   assign pay2    = {16'b0, data[63:40], head};
   assign len1    = first_n + HDR_BYTES;
   assign len2    = flen - (FRAG_BYTES - HDR_BYTES);

   assign rsp_fire = valid_ff && rsp_ready;
   assign out_free = !valid_ff || (rsp_ready && !pend_ff);
   assign s1_take  = s1.valid && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else if (s1_take) begin
         valid_ff <= 1'b1;
         pend_ff  <= s1.recv && split;
      end else if (rsp_fire) begin
         if (pend_ff) begin
            pend_ff <= 1'b0;
         end else begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         port_ff <= s1.port;
         id_ff   <= s1.id;
         if (s1.recv) begin
            len_ff      <= len1;
            pay_ff      <= pay1;
            last_ff     <= !split;
            pend_len_ff <= len2;
            pend_pay_ff <= pay2;
         end else begin
            len_ff  <= s1.len;
            pay_ff  <= s1.payload;
            last_ff <= 1'b1;
         end
      end else if (rsp_fire && pend_ff) begin
         len_ff  <= pend_len_ff;
         pay_ff  <= pend_pay_ff;
         last_ff <= 1'b1;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_reply_port    = port_ff;
   assign rsp_reply_id      = id_ff;
   assign rsp_reply_length  = len_ff;
   assign rsp_reply_payload = pay_ff;
   assign rsp_last_of_run   = last_ff;

endmodule

FILE: rtl/can_slot_relay_responder.sv
// ----------------------------------------------------------------------------
// can_slot_relay_responder
// Two-bus CAN slot relay: queues downlink frames, answers uplink frames in
// the slot window with status, forward or queued-frame fragments.
//
//   channel  dir   handshake              payload
//   req      in    req_valid/req_ready    cmd, frame id/length/payload, pins
//   rsp      out   rsp_valid/rsp_ready    reply port/id/length/payload, last
//   csr      in    csr_valid/csr_ready    csr_index, csr_data
//
// A word is taken every cycle unless rsp_ready stalls the output; a receive
// request that splits into two fragments holds the result register until both are sent.
// The path runs through decode plus queue memory read, then the result register.
// Synchronous reset clears pointers, count, CSR registers and valids; the queue
// memory is not cleared. csr_ready is always high.
// ----------------------------------------------------------------------------
module can_slot_relay_responder
   import csrr_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_cmd,
   input  logic [ID_W-1:0]      req_frame_id,
   input  logic [LEN_W-1:0]     req_frame_length,
   input  logic [DATA_W-1:0]    req_frame_payload,
   input  logic [5:0]           req_endstop_pins,
   input  logic [2:0]           req_fault_pins,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_reply_port,
   output logic [RID_W-1:0]     rsp_reply_id,
   output logic [LEN_W-1:0]     rsp_reply_length,
   output logic [DATA_W-1:0]    rsp_reply_payload,
   output logic                 rsp_last_of_run,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   logic [ID_W-1:0]  win_base_ff;
   logic [OFS_W-1:0] send_ofs_ff, recv_ofs_ff;

   s1_word_type s1_ff, s1_in;
   q_ctrl_type  q_ctrl;
   logic        s1_take, q_empty, req_fire;
   logic [ENTRY_W-1:0] rd_data;

   logic [LEN_W-1:0]  len_c, fwd_len;
   logic [DATA_W-1:0] pay_m;
   logic [ID_W:0]     win_top, sum_status, sum_recv;
   logic [ID_W-1:0]   diff;
   logic [OFS_W-1:0]  offset;
   logic              in_win, is_status, is_send, is_recv, do_fwd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_base_ff <= WIN_BASE_RST;
         send_ofs_ff <= SEND_OFS_RST;
         recv_ofs_ff <= RECV_OFS_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WIN_BASE: win_base_ff <= csr_data;
            CSR_SEND_OFS: send_ofs_ff <= csr_data[OFS_W-1:0];
            CSR_RECV_OFS: recv_ofs_ff <= csr_data[OFS_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ready = !s1_ff.valid || s1_take;
   assign req_fire  = req_valid && req_ready;

   assign len_c      = (req_frame_length > MAX_BYTES) ? MAX_BYTES : req_frame_length;
   assign pay_m      = req_frame_payload & bytes_mask(len_c);
   assign win_top    = {1'b0, win_base_ff} + {{(ID_W-OFS_W+1){1'b0}}, WINDOW_SPAN};
   assign sum_status = {1'b0, win_base_ff} + {{(ID_W-OFS_W+1){1'b0}}, OFS_STATUS};
   assign sum_recv   = {1'b0, win_base_ff} + {{(ID_W-OFS_W+1){1'b0}}, recv_ofs_ff};
   assign diff       = req_frame_id - win_base_ff;
   assign offset     = diff[OFS_W-1:0];
   assign in_win     = req_cmd && (req_frame_id >= win_base_ff) &&
                       ({1'b0, req_frame_id} <= win_top);
   assign is_status  = in_win && (offset == OFS_STATUS);
   assign is_send    = in_win && !is_status && (offset == send_ofs_ff);
   assign is_recv    = in_win && !is_status && !is_send && (offset == recv_ofs_ff);
   assign do_fwd     = is_send && (len_c >= HDR_BYTES);
   assign fwd_len    = len_c - HDR_BYTES;

   assign q_ctrl.push = req_fire && !req_cmd;
   assign q_ctrl.pop  = req_fire && is_recv && !q_empty;

   always_comb begin
      s1_in = s1_ff;
      if (req_fire) begin
         s1_in.valid   = is_status || do_fwd || (is_recv && !q_empty);
         s1_in.recv    = is_recv;
         s1_in.port    = do_fwd ? PORT_DOWNLINK : PORT_UPLINK;
         s1_in.len     = is_status ? STATUS_LEN : fwd_len;
         s1_in.id      = is_status ? {{(RID_W-ID_W-1){1'b0}}, sum_status}
                       : is_recv   ? {{(RID_W-ID_W-1){1'b0}}, sum_recv}
                       : {req_frame_payload[7:0], req_frame_payload[15:8]};
         s1_in.payload = is_status
                       ? {{(DATA_W-11){1'b0}}, ~req_fault_pins, 2'b0, ~req_endstop_pins}
                       : (req_frame_payload >> 24) & bytes_mask(fwd_len);
      end else if (s1_take) begin
         s1_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else begin
         s1_ff.valid <= s1_in.valid;
      end
      s1_ff.recv    <= s1_in.recv;
      s1_ff.port    <= s1_in.port;
      s1_ff.id      <= s1_in.id;
      s1_ff.len     <= s1_in.len;
      s1_ff.payload <= s1_in.payload;
   end

   csrr_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (q_ctrl),
      .wr_data ({len_c, req_frame_id, pay_m}),
      .empty   (q_empty),
      .rd_data (rd_data)
   );

   csrr_out u_out (
      .clock             (clock),
      .reset             (reset),
      .s1                (s1_ff),
      .rd_data           (rd_data),
      .s1_take           (s1_take),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_reply_port    (rsp_reply_port),
      .rsp_reply_id      (rsp_reply_id),
      .rsp_reply_length  (rsp_reply_length),
      .rsp_reply_payload (rsp_reply_payload),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule
